// ----- hdl/kvs_pkg.sv -----
package kvs_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int TIME_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 7;
    localparam int IDX_W = 6;
    localparam int FRAC_W = 17;

    localparam logic [1:0] REGION_FIRST = 2'd0;
    localparam logic [1:0] REGION_SEG = 2'd1;
    localparam logic [1:0] REGION_LAST = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Input item as it is held in the queue between front and back.
    typedef struct packed {
        logic req_type;
        logic [IDX_W-1:0] key_index;
        logic [TIME_W-1:0] key_time;
        logic [VAL_W-1:0] key_x;
        logic [VAL_W-1:0] key_y;
        logic [VAL_W-1:0] key_z;
        logic [TIME_W-1:0] sample_time;
    } req_t;

    // Result item as the back part hands it to the output register.
    typedef struct packed {
        logic [VAL_W-1:0] value_x;
        logic [VAL_W-1:0] value_y;
        logic [VAL_W-1:0] value_z;
        logic [1:0] region;
        logic [IDX_W-1:0] segment_start;
    } res_t;

endpackage

// ----- hdl/kvs_ram.sv -----
module kvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/kvs_front.sv -----
module kvs_front #(
    parameter int MAX_KEYS = kvs_pkg::MAX_KEYS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  kvs_pkg::req_t in_req,
    output logic          q_valid,
    input  logic          q_ready,
    output kvs_pkg::req_t q_req
);
    import kvs_pkg::*;

    // Two-entry queue; a write item whose index is out of range is dropped here.
    req_t buf_reg [2];
    logic [1:0] cnt_reg;
    logic rd_reg;
    logic wr_ptr_reg;
    logic push;
    logic pop;
    logic keep;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req = buf_reg[rd_reg];
    assign pop = q_valid && q_ready;
    assign keep = (in_req.req_type == REQ_SAMPLE) || (32'(in_req.key_index) < MAX_KEYS);
    assign push = in_valid && in_ready && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

// ----- hdl/kvs_back.sv -----
module kvs_back #(
    parameter int MAX_KEYS = kvs_pkg::MAX_KEYS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [kvs_pkg::CNT_W-1:0] key_count,
    input  logic          q_valid,
    output logic          q_ready,
    input  kvs_pkg::req_t q_req,
    output logic          res_valid,
    input  logic          res_ready,
    output kvs_pkg::res_t res,
    output logic          busy
);
    import kvs_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int NW = $clog2(MAX_KEYS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0 = 4'd1;
    localparam logic [3:0] S_T0 = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_CMP = 4'd4;
    localparam logic [3:0] S_DIV = 4'd5;
    localparam logic [3:0] S_VRD = 4'd6;
    localparam logic [3:0] S_VA = 4'd7;
    localparam logic [3:0] S_VB = 4'd8;
    localparam logic [3:0] S_MUL = 4'd9;
    localparam logic [3:0] S_SUM = 4'd10;
    localparam logic [3:0] S_OUT = 4'd11;

    logic [3:0] state_reg;
    logic [AW-1:0] raddr;
    logic [AW-1:0] i_reg;
    logic [AW-1:0] va_reg;
    logic [AW-1:0] vb_reg;
    logic [NW-1:0] n_reg;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] t0_reg;
    logic [TIME_W-1:0] trd;
    logic [VAL_W-1:0] xrd;
    logic [VAL_W-1:0] yrd;
    logic [VAL_W-1:0] zrd;
    logic [VAL_W-1:0] a_reg [3];
    logic [VAL_W-1:0] b_reg [3];
    logic signed [VAL_W+FRAC_W+1:0] p_reg [3];
    logic [1:0] region_reg;
    logic [IDX_W-1:0] seg_reg;
    logic [FRAC_W-1:0] f_reg;
    logic [TIME_W:0] rem_reg;
    logic [TIME_W-1:0] span_reg;
    logic [5:0] dcnt_reg;
    logic [TIME_W+1:0] trial;
    logic we;
    logic [AW-1:0] waddr;
    logic [NW-1:0] n_clamp;

    assign we = q_valid && q_ready && (q_req.req_type == REQ_WRITE);
    assign waddr = AW'(q_req.key_index);
    assign q_ready = (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign trial = {1'b0, rem_reg} - {2'b0, span_reg};

    // Clamp the key count into 1..MAX_KEYS.
    always_comb
    begin
        if (key_count == '0)
        begin
            n_clamp = NW'(1);
        end
        else if (32'(key_count) > MAX_KEYS)
        begin
            n_clamp = NW'(MAX_KEYS);
        end
        else
        begin
            n_clamp = NW'(key_count);
        end
    end

    // The read address follows the step of the sequencer.
    always_comb
    begin
        case (state_reg)
            S_IDLE: raddr = '0;
            S_T0, S_SCAN: raddr = i_reg + AW'(1);
            S_VRD: raddr = va_reg;
            S_VA: raddr = vb_reg;
            default: raddr = i_reg;
        endcase
    end

    kvs_ram #(.WIDTH(TIME_W), .DEPTH(MAX_KEYS)) u_t (
        .clk(clk), .we(we), .waddr(waddr), .wdata(q_req.key_time), .raddr(raddr), .rdata(trd));
    kvs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KEYS)) u_x (
        .clk(clk), .we(we), .waddr(waddr), .wdata(q_req.key_x), .raddr(raddr), .rdata(xrd));
    kvs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KEYS)) u_y (
        .clk(clk), .we(we), .waddr(waddr), .wdata(q_req.key_y), .raddr(raddr), .rdata(yrd));
    kvs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KEYS)) u_z (
        .clk(clk), .we(we), .waddr(waddr), .wdata(q_req.key_z), .raddr(raddr), .rdata(zrd));

    // Sequencer: scan the segments, divide one bit a cycle, then blend.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && q_req.req_type == REQ_SAMPLE)
                    begin
                        state_reg <= S_RD0;
                    end
                end
                S_RD0: state_reg <= S_T0;
                S_T0:
                begin
                    if (n_reg == NW'(1) || t_reg <= trd)
                    begin
                        state_reg <= S_VRD;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: state_reg <= S_CMP;
                S_CMP:
                begin
                    if (t0_reg <= t_reg && t_reg <= trd)
                    begin
                        state_reg <= S_DIV;
                    end
                    else if (NW'(i_reg) + NW'(2) >= n_reg)
                    begin
                        state_reg <= S_VRD;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_DIV:
                begin
                    if (dcnt_reg == 6'd0)
                    begin
                        state_reg <= S_VRD;
                    end
                end
                S_VRD: state_reg <= S_VA;
                S_VA: state_reg <= S_VB;
                S_VB: state_reg <= S_MUL;
                S_MUL: state_reg <= S_SUM;
                S_SUM: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                t_reg <= q_req.sample_time;
                n_reg <= n_clamp;
                i_reg <= '0;
            end
            S_T0:
            begin
                t0_reg <= trd;
                va_reg <= '0;
                vb_reg <= '0;
                f_reg <= '0;
                region_reg <= REGION_FIRST;
                seg_reg <= '0;
            end
            S_CMP:
            begin
                if (t0_reg <= t_reg && t_reg <= trd)
                begin
                    va_reg <= i_reg;
                    vb_reg <= i_reg + AW'(1);
                    region_reg <= REGION_SEG;
                    seg_reg <= IDX_W'(i_reg);
                    span_reg <= trd - t0_reg;
                    rem_reg <= {1'b0, t_reg - t0_reg};
                    dcnt_reg <= 6'(FRAC_W);
                    f_reg <= '0;
                end
                else if (NW'(i_reg) + NW'(2) >= n_reg)
                begin
                    va_reg <= AW'(n_reg - NW'(1));
                    vb_reg <= AW'(n_reg - NW'(1));
                    region_reg <= REGION_LAST;
                    seg_reg <= '0;
                    f_reg <= '0;
                end
                else
                begin
                    t0_reg <= trd;
                    i_reg <= i_reg + AW'(1);
                end
            end
            S_DIV:
            begin
                // Restoring division of (t - t0) << 16 by span, one quotient bit per
                // cycle from bit 16 down; the remainder never exceeds twice the span.
                if (dcnt_reg != 6'd0)
                begin
                    dcnt_reg <= dcnt_reg - 6'd1;
                    if (span_reg == '0)
                    begin
                        f_reg <= '0;
                    end
                    else if (!trial[TIME_W+1])
                    begin
                        rem_reg <= {trial[TIME_W-1:0], 1'b0};
                        f_reg <= {f_reg[FRAC_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[TIME_W-1:0], 1'b0};
                        f_reg <= {f_reg[FRAC_W-2:0], 1'b0};
                    end
                end
            end
            S_VA:
            begin
                a_reg[0] <= xrd;
                a_reg[1] <= yrd;
                a_reg[2] <= zrd;
            end
            S_VB:
            begin
                b_reg[0] <= xrd;
                b_reg[1] <= yrd;
                b_reg[2] <= zrd;
            end
            S_MUL:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p_reg[k] <= (($signed({b_reg[k][VAL_W-1], b_reg[k]})
                        - $signed({a_reg[k][VAL_W-1], a_reg[k]}))
                        * $signed({1'b0, f_reg}));
                end
            end
            S_SUM:
            begin
                res.value_x <= a_reg[0] + VAL_W'(p_reg[0] >>> 16);
                res.value_y <= a_reg[1] + VAL_W'(p_reg[1] >>> 16);
                res.value_z <= a_reg[2] + VAL_W'(p_reg[2] >>> 16);
                res.region <= region_reg;
                res.segment_start <= seg_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hdl/keyframe_vector_sampler_top.sv -----
// Keyframe vector sampler.
// Input channel s_axis_*: tuser carries req_type (0 write key, 1 sample).
// A write item stores key_time and the x, y, z value at key_index and gives
// no result. A sample item gives one result on m_axis_*: the vector at
// sample_time, held at the first key, blended inside the first enclosing
// segment, or held at the last key, with region and segment_start.
// key_count is written through cfg_we/cfg_wdata; the user must do so only while
// the block is idle, as the block itself does not enforce it. A sample scans the
// segments one by one, a key memory read per step, then runs the bit-serial
// fraction divider when it interpolates; these reads and the divider set how long
// a sample takes. Items run one at a time in the back part; a two-item queue lets
// the input side accept while a result waits. If the receiver stalls, the
// result holds on m_axis_tdata and the queue fills, then s_axis_tready drops.
// Reset empties the queue, sets key_count to 1 and leaves the key table
// undefined until written.
module keyframe_vector_sampler_top #(
    parameter int MAX_KEYS = kvs_pkg::MAX_KEYS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key_index[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
    // key_z[133:102], sample_time[165:134], zero fill to 168
    input  logic [167:0] s_axis_tdata,
    // req_type
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // value_x[31:0], value_y[63:32], value_z[95:64], region[97:96],
    // segment_start[103:98]
    output logic [103:0] m_axis_tdata
);
    import kvs_pkg::*;

    logic [CNT_W-1:0] key_count_reg;
    req_t in_req;
    req_t q_req;
    res_t res;
    logic q_valid;
    logic q_ready;
    logic busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            key_count_reg <= cfg_wdata;
        end
    end

    // Unpack the input item.
    assign in_req.req_type = s_axis_tuser;
    assign in_req.key_index = s_axis_tdata[5:0];
    assign in_req.key_time = s_axis_tdata[37:6];
    assign in_req.key_x = s_axis_tdata[69:38];
    assign in_req.key_y = s_axis_tdata[101:70];
    assign in_req.key_z = s_axis_tdata[133:102];
    assign in_req.sample_time = s_axis_tdata[165:134];

    kvs_front #(.MAX_KEYS(MAX_KEYS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req));

    kvs_back #(.MAX_KEYS(MAX_KEYS)) u_back (
        .clk(clk), .rst_n(rst_n), .key_count(key_count_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res), .busy(busy));

    assign m_axis_tdata = {res.segment_start, res.region, res.value_z, res.value_y,
        res.value_x};

    // A result is only shown while the back part is working on a sample.
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> busy)
        else $error("result valid while back part idle");

    // The back part takes no queue item while busy.
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !q_ready)
        else $error("queue popped while busy");

    // A result that is taken leaves the back part idle next cycle.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result repeated");

endmodule

// ----- verif/tb.sv -----
module tb;
    import kvs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 250;
    localparam int SAMPLES_PER_PHASE = 160;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t kind;
        logic req;
        logic [5:0] kidx;
        logic [31:0] ktime;
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
        logic [31:0] stime;
        logic [6:0] cfg_val;
        bit typed;
        res_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [6:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [167:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;

    // Our own copy of the key table and the key count.
    logic [31:0] tab_time [MAX_KEYS_DEF];
    logic [31:0] tab_x [MAX_KEYS_DEF];
    logic [31:0] tab_y [MAX_KEYS_DEF];
    logic [31:0] tab_z [MAX_KEYS_DEF];
    int keys_used = 1;

    res_t pending_samples [$];
    dir_row_t dir_rows [$];
    int errors = 0;
    int cycles = 0;
    int hold_len = 0;
    bit no_gaps = 0;

    keyframe_vector_sampler_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Append one row to the directed table.
    function automatic void add_row(input dir_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Linear blend v0 + floor((v1 - v0) * f / 2^16).
    function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                          input logic [16:0] f);
        logic signed [63:0] v0;
        logic signed [63:0] v1;
        logic signed [63:0] p;
        logic signed [63:0] r;
        v0 = {{32{a[31]}}, a};
        v1 = {{32{b[31]}}, b};
        p = (v1 - v0) * $signed({47'b0, f});
        r = v0 + (p >>> 16);
        return r[31:0];
    endfunction

    function automatic res_t vector_at(input int i, input int j, input logic [16:0] f,
                                       input logic [1:0] region, input int seg);
        res_t r;
        r.value_x = blend(tab_x[i], tab_x[j], f);
        r.value_y = blend(tab_y[i], tab_y[j], f);
        r.value_z = blend(tab_z[i], tab_z[j], f);
        r.region = region;
        r.segment_start = seg[5:0];
        return r;
    endfunction

    // Expected vector for a sample at time t.
    function automatic res_t sample_keys(input logic [31:0] t);
        int n;
        logic [63:0] num;
        logic [63:0] span;
        logic [63:0] q;
        n = keys_used;
        if (n < 1)
            n = 1;
        if (n > MAX_KEYS_DEF)
            n = MAX_KEYS_DEF;
        if (n == 1 || t <= tab_time[0])
            return vector_at(0, 0, 17'd0, REGION_FIRST, 0);
        for (int i = 0; i + 1 < n; i++)
        begin
            if (tab_time[i] <= t && t <= tab_time[i + 1])
            begin
                span = {32'b0, tab_time[i + 1] - tab_time[i]};
                q = 64'd0;
                if (span != 0)
                begin
                    num = {32'b0, t - tab_time[i]} << 16;
                    q = num / span;
                end
                return vector_at(i, i + 1, q[16:0], REGION_SEG, i);
            end
        end
        return vector_at(n - 1, n - 1, 17'd0, REGION_LAST, 0);
    endfunction

    // Offer one item after a random gap, wait for it to be taken, then predict.
    task automatic send_item(input req_t it, input bit typed, input res_t want);
        int gap;
        gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.req_type;
        s_axis_tdata <= {2'b0, it.sample_time, it.key_z, it.key_y, it.key_x,
                         it.key_time, it.key_index};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (it.req_type == REQ_WRITE)
        begin
            tab_time[it.key_index] = it.key_time;
            tab_x[it.key_index] = it.key_x;
            tab_y[it.key_index] = it.key_y;
            tab_z[it.key_index] = it.key_z;
        end
        else
            pending_samples.insert(pending_samples.size(),
                                   typed ? want : sample_keys(it.sample_time));
    endtask

    // Register writes wait until the block has drained.
    task automatic set_key_count(input logic [6:0] v);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_samples.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        keys_used = v;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t write_req(input int idx, input logic [31:0] t);
        req_t r;
        r.req_type = REQ_WRITE;
        r.key_index = idx[5:0];
        r.key_time = t;
        r.key_x = rand_value();
        r.key_y = rand_value();
        r.key_z = rand_value();
        r.sample_time = $urandom;
        return r;
    endfunction

    // Receiver: random stalls, and one long hold-off when asked.
    initial
    begin
        int w;
        forever
        begin
            if (hold_len > 0)
            begin
                w = hold_len;
                hold_len = 0;
            end
            else
                w = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (w > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (w - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_samples.size() == 0)
            begin
                report("unexpected result", m_axis_tdata[31:0], 32'h0);
            end
            else
            begin
                want = pending_samples.pop_front();
                if (m_axis_tdata[31:0] !== want.value_x)
                    report("value_x", m_axis_tdata[31:0], want.value_x);
                if (m_axis_tdata[63:32] !== want.value_y)
                    report("value_y", m_axis_tdata[63:32], want.value_y);
                if (m_axis_tdata[95:64] !== want.value_z)
                    report("value_z", m_axis_tdata[95:64], want.value_z);
                if (m_axis_tdata[97:96] !== want.region)
                    report("region", {30'b0, m_axis_tdata[97:96]}, {30'b0, want.region});
                if (m_axis_tdata[103:98] !== want.segment_start)
                    report("segment_start", {26'b0, m_axis_tdata[103:98]},
                           {26'b0, want.segment_start});
            end
        end
    end

    initial
    begin
        req_t it;
        dir_row_t row;
        res_t none;
        logic [63:0] acc;
        logic [6:0] counts [8];
        int n;
        int mode;
        int k;

        none = '0;

        // Directed rows: single key, extremes, interior, exact end, past end.
        add_row('{ROW_ITEM, REQ_WRITE, 6'd0, 32'h00010000, 32'h7fffffff,
                  32'h80000000, 32'h0, 32'h0, 7'd0, 0, none});
        add_row('{ROW_ITEM, REQ_SAMPLE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h0, 7'd0, 1,
                  '{32'h7fffffff, 32'h80000000, 32'h0, REGION_FIRST, 6'd0}});
        add_row('{ROW_ITEM, REQ_SAMPLE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'hffffffff, 7'd0, 1,
                  '{32'h7fffffff, 32'h80000000, 32'h0, REGION_FIRST, 6'd0}});
        add_row('{ROW_ITEM, REQ_WRITE, 6'd1, 32'h00020000, 32'h80000000,
                  32'h7fffffff, 32'h00010000, 32'h0, 7'd0, 0, none});
        add_row('{ROW_ITEM, REQ_WRITE, 6'd2, 32'h00020000, 32'h1, 32'h2, 32'h3,
                  32'h0, 7'd0, 0, none});
        add_row('{ROW_ITEM, REQ_WRITE, 6'd3, 32'hffffffff, 32'hffffffff,
                  32'h0, 32'h80000000, 32'h0, 7'd0, 0, none});
        add_row('{ROW_ITEM, REQ_WRITE, 6'd63, 32'hffffffff, 32'h0, 32'hffffffff,
                  32'h7fffffff, 32'h0, 7'd0, 0, none});
        add_row('{ROW_CFG, REQ_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                  7'd4, 0, none});
        add_row('{ROW_ITEM, REQ_SAMPLE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h00010000, 7'd0, 1,
                  '{32'h7fffffff, 32'h80000000, 32'h0, REGION_FIRST, 6'd0}});
        add_row('{ROW_ITEM, REQ_SAMPLE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h00018000, 7'd0, 0, none});
        add_row('{ROW_ITEM, REQ_SAMPLE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h00020000, 7'd0, 1,
                  '{32'h80000000, 32'h7fffffff, 32'h00010000, REGION_SEG, 6'd0}});
        add_row('{ROW_ITEM, REQ_SAMPLE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h00030000, 7'd0, 0, none});
        add_row('{ROW_ITEM, REQ_SAMPLE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'hffffffff, 7'd0, 0, none});
        // Three keys: the last two share a time, so a zero-length segment ends the table.
        add_row('{ROW_CFG, REQ_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                  7'd3, 0, none});
        add_row('{ROW_ITEM, REQ_SAMPLE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h00030000, 7'd0, 1,
                  '{32'h1, 32'h2, 32'h3, REGION_LAST, 6'd0}});
        add_row('{ROW_ITEM, REQ_SAMPLE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h00020000, 7'd0, 0, none});
        add_row('{ROW_ITEM, REQ_SAMPLE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h00011234, 7'd0, 0, none});
        // A key count of zero behaves like one.
        add_row('{ROW_CFG, REQ_WRITE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                  7'd0, 0, none});
        add_row('{ROW_ITEM, REQ_SAMPLE, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h00050000, 7'd0, 1,
                  '{32'h7fffffff, 32'h80000000, 32'h0, REGION_FIRST, 6'd0}});

        // Reset once.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            if (row.kind == ROW_CFG)
                set_key_count(row.cfg_val);
            else
            begin
                it.req_type = row.req;
                it.key_index = row.kidx;
                it.key_time = row.ktime;
                it.key_x = row.kx;
                it.key_y = row.ky;
                it.key_z = row.kz;
                it.sample_time = row.stime;
                send_item(it, row.typed, row.want);
            end
        end

        // Random phases over several key counts, the extremes among them.
        counts[0] = 7'd2;
        counts[1] = 7'd64;
        counts[2] = 7'd127;
        counts[3] = 7'd1;
        counts[4] = 7'd65;
        counts[5] = 7'd0;
        counts[6] = 7'd3;
        counts[7] = 7'($urandom_range(4, 63));
        for (int ph = 0; ph < 8; ph++)
        begin
            set_key_count(counts[ph]);
            n = counts[ph];
            if (n < 1)
                n = 1;
            if (n > MAX_KEYS_DEF)
                n = MAX_KEYS_DEF;
            no_gaps = (ph == 4);

            // Load every key in use: mostly ordered times, some unordered or equal.
            mode = $urandom_range(0, 9);
            acc = {32'b0, ($urandom_range(0, 3) == 0) ? 32'h0 : 32'($urandom_range(0, 32'h40000))};
            for (int i = 0; i < n; i++)
            begin
                if (mode == 0)
                    it = write_req(i, $urandom);
                else if (mode == 1)
                    it = write_req(i, acc[31:0] + 32'($urandom_range(0, 1) << 16));
                else
                begin
                    it = write_req(i, acc[31:0]);
                    acc = acc + (($urandom_range(0, 4) == 0) ? 64'd0 :
                                 64'($urandom_range(1, 32'h30000)));
                    if ($urandom_range(0, 30) == 0)
                        acc = acc + 64'h40000000;
                    if (acc > 64'hffffffff)
                        acc = 64'hffffffff;
                end
                send_item(it, 0, none);
            end

            if (ph == 1)
                hold_len = 1500;

            for (int s = 0; s < SAMPLES_PER_PHASE; s++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    k = $urandom_range(0, MAX_KEYS_DEF - 1);
                    it = write_req(k, $urandom);
                end
                else
                begin
                    it = write_req(0, 32'h0);
                    it.req_type = REQ_SAMPLE;
                    k = $urandom_range(0, n - 1);
                    case ($urandom_range(0, 9))
                        0: it.sample_time = $urandom;
                        1: it.sample_time = 32'h0;
                        2: it.sample_time = 32'hffffffff;
                        3, 4: it.sample_time = tab_time[k];
                        5: it.sample_time = tab_time[k] + 32'd1;
                        default:
                        begin
                            acc = {32'b0, tab_time[k]} + 64'($urandom_range(0, 32'h30000));
                            it.sample_time = (acc > 64'hffffffff) ? 32'hffffffff : acc[31:0];
                        end
                    endcase
                end
                send_item(it, 0, none);
            end
        end

        // Drain and finish.
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_samples.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- keyframe_vector_sampler_top.f -----
hdl/kvs_pkg.sv
hdl/kvs_ram.sv
hdl/kvs_front.sv
hdl/kvs_back.sv
hdl/keyframe_vector_sampler_top.sv
verif/tb.sv
